FILE: design/fir_filter_real_complex_defines.svh
// Assertion macros for the FIR filter block.
// Taken in by the files that carry concurrent checks; no other dependencies.
`ifndef FIR_FILTER_REAL_COMPLEX_DEFINES_SVH
`define FIR_FILTER_REAL_COMPLEX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FIRC_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FIRC_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: design/firc_pkg.sv
// Shared codes and types for the FIR filter block.
// No dependencies; imported by firc_mac and fir_filter_real_complex.
package firc_pkg;

    localparam int OP_W       = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int COEF_IDX_W = 8;

    // request operations
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_COEF_I = 2'd1;
    localparam logic [OP_W-1:0] OP_COEF_Q = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // filter modes
    localparam logic [MODE_W-1:0] MODE_REAL    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HILBERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPLEX = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'd1;

    // control passed from the sequencer to the MAC pipeline
    typedef struct packed {
        logic start;   // a sample request was accepted
        logic vld;     // read data valid this cycle
        logic first;   // first tap of the sum
        logic last;    // last tap of the sum
        logic cplx;    // quadrature output in use
    } t_mac_ctrl;

endpackage

FILE: design/firc_mac.sv
// Multiply-accumulate pipeline with rounding and saturation for the FIR filter.
// Depends on firc_pkg (t_mac_ctrl).
module firc_mac #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18,
    parameter int MAX_TAPS    = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  firc_pkg::t_mac_ctrl           i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_dre,
    input  logic signed [SAMPLE_BITS-1:0] i_dim,
    input  logic signed [COEF_BITS-1:0]   i_cre,
    input  logic signed [COEF_BITS-1:0]   i_cim,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_re,
    output logic signed [SAMPLE_BITS-1:0] o_im,
    output logic                          o_ovf
);
    import firc_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int FRAC   = COEF_BITS - 2;
    localparam int RND_W  = ACC_W + 1;
    localparam int V_W    = RND_W - FRAC;
    localparam logic signed [RND_W-1:0] HALF =
        {{(RND_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // product stage
    logic                     r_p_vld;
    logic                     r_p_first;
    logic                     r_p_last;
    logic                     r_p_cplx;
    logic signed [PROD_W-1:0] r_prod_re;
    logic signed [PROD_W-1:0] r_prod_im;

    // accumulate stage
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic                    r_a_cplx;
    logic                    r_done;

    logic [SAMPLE_BITS:0] fin_re;
    logic [SAMPLE_BITS:0] fin_im;

    // round half up, shift out the fraction, saturate; {sat, value}
    function automatic logic [SAMPLE_BITS:0] finish(input logic signed [ACC_W-1:0] a);
        logic signed [RND_W-1:0] r;
        logic signed [V_W-1:0]   v;
        logic                    fits;
        r    = RND_W'(a) + HALF;
        v    = V_W'(r >>> FRAC);
        fits = (&v[V_W-1:SAMPLE_BITS-1]) | ~(|v[V_W-1:SAMPLE_BITS-1]);
        if (fits) begin
            finish = {1'b0, v[SAMPLE_BITS-1:0]};
        end else begin
            finish = {1'b1, (v[V_W-1] ? S_MIN : S_MAX)};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_ctrl.vld;
        end
        r_p_first <= i_ctrl.first;
        r_p_last  <= i_ctrl.last;
        r_p_cplx  <= i_ctrl.cplx;
        r_prod_re <= i_dre * i_cre;
        r_prod_im <= i_dim * i_cim;
    end

    always_ff @(posedge i_clk) begin
        if (r_p_vld) begin
            r_acc_re <= (r_p_first ? ACC_W'(0) : r_acc_re) + ACC_W'(r_prod_re);
            r_acc_im <= (r_p_first ? ACC_W'(0) : r_acc_im) + ACC_W'(r_prod_im);
            r_a_cplx <= r_p_cplx;
        end
    end

    // done stays up until the next sample starts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (i_ctrl.start) begin
            r_done <= 1'b0;
        end else if (r_p_vld && r_p_last) begin
            r_done <= 1'b1;
        end
    end

    assign fin_re = finish(r_acc_re);
    assign fin_im = finish(r_acc_im);

    assign o_done = r_done;
    assign o_re   = fin_re[SAMPLE_BITS-1:0];
    assign o_im   = r_a_cplx ? fin_im[SAMPLE_BITS-1:0] : '0;
    assign o_ovf  = fin_re[SAMPLE_BITS] | (r_a_cplx & fin_im[SAMPLE_BITS]);

endmodule

FILE: design/fir_filter_real_complex.sv
// Direct-form FIR filter, real / Hilbert / complex, over circular delay-line memories.
// Depends on firc_pkg, firc_mac and fir_filter_real_complex_defines.svh.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------------
//  s_axis   | in        | tuser: operation; tdata: sample_re, sample_im, coef_index,
//           |           |        coef_value
//  m_axis   | out       | tuser: overflow; tdata: out_re, out_im
//  cfg      | in        | index 0 tap_count, index 1 filter_mode
//
// A sample request runs from acceptance to a valid result as follows: one delay-line
// and coefficient read per tap on the single read port of each memory, then the
// product and accumulate registers, combinational rounding and the output register.
// Coefficient writes are done without leaving the idle state. A clear request or a
// tap_count write runs a zeroing sweep over delay-line entries 0 to tap_count-1;
// after reset the sweep covers one entry. Only entries below tap_count are ever read.
// The result sits in an output register; while it waits, requests are still taken.
// A later sample finishes its sum and then holds s_axis_tready low in the wait
// state until the output register frees up.
`include "fir_filter_real_complex_defines.svh"

module fir_filter_real_complex #(
    parameter int MAX_TAPS    = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // request stream
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [SB-1:0] sample_re, [2SB-1:SB] sample_im, [2SB+7:2SB] coef_index,
    // [2SB+8+CB-1:2SB+8] coef_value, zero padding above
    input  logic [((2*SAMPLE_BITS+8+COEF_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [1:0] operation
    input  logic [firc_pkg::OP_W-1:0]                  s_axis_tuser,
    // result stream
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // [SB-1:0] out_re, [2SB-1:SB] out_im, zero padding above
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata,
    // [0] overflow
    output logic                                       m_axis_tuser,
    // register writes
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [firc_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [firc_pkg::CFG_DATA_W-1:0]            i_cfg_data
);
    import firc_pkg::*;

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int TC_W  = $clog2(MAX_TAPS + 1);
    localparam int CMP_W = (TC_W > CFG_DATA_W) ? TC_W : CFG_DATA_W;
    localparam int F_IM  = SAMPLE_BITS;
    localparam int F_IDX = 2 * SAMPLE_BITS;
    localparam int F_CF  = 2 * SAMPLE_BITS + COEF_IDX_W;
    localparam int OUT_TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [ST_W-1:0] ST_CLEAR = 2'd1;
    localparam logic [ST_W-1:0] ST_RUN   = 2'd2;
    localparam logic [ST_W-1:0] ST_WAIT  = 2'd3;

    // control state
    logic [ST_W-1:0]   r_state, n_state;
    logic [AW-1:0]     r_j, n_j;          // delay-line address / sweep address
    logic [AW-1:0]     r_k, n_k;          // coefficient address
    logic [AW-1:0]     r_pos, n_pos;      // write position
    logic [TC_W-1:0]   r_taps, n_taps;
    logic [MODE_W-1:0] r_mode, n_mode;

    // memories
    logic signed [SAMPLE_BITS-1:0] r_dl_re [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_dl_im [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   r_cf_i  [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   r_cf_q  [MAX_TAPS];

    // registered read data and its control
    logic signed [SAMPLE_BITS-1:0] r_rd_dre, r_rd_dim;
    logic signed [COEF_BITS-1:0]   r_rd_ci, r_rd_cq;
    logic                          r_rd_vld, r_rd_first, r_rd_last, r_rd_cplx;

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_re, r_out_im;
    logic                          r_out_ovf;

    // request fields
    logic [OP_W-1:0]               in_op;
    logic signed [SAMPLE_BITS-1:0] in_re, in_im;
    logic [COEF_IDX_W-1:0]         in_idx;
    logic signed [COEF_BITS-1:0]   in_coef;

    logic                          in_acc, smp_acc, cfg_acc;
    logic                          cplx_out, cplx_in, idx_ok;
    logic [TC_W-1:0]               taps_m1;
    logic                          j_last, k_last;
    logic [AW-1:0]                 pos_eff, pos_next, k_start;
    logic [TC_W-1:0]               taps_sat;

    logic                          dl_we, ci_we, cq_we, cap, out_free;
    logic [AW-1:0]                 dl_waddr;
    logic signed [SAMPLE_BITS-1:0] dl_wre, dl_wim;

    t_mac_ctrl                     mac_ctrl;
    logic                          mac_done, mac_ovf;
    logic signed [SAMPLE_BITS-1:0] mac_re, mac_im;

    // field unpacking
    assign in_op   = s_axis_tuser;
    assign in_re   = s_axis_tdata[F_IM-1:0];
    assign in_im   = s_axis_tdata[F_IDX-1:F_IM];
    assign in_idx  = s_axis_tdata[F_CF-1:F_IDX];
    assign in_coef = s_axis_tdata[F_CF+COEF_BITS-1:F_CF];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign smp_acc = in_acc && (in_op == OP_SAMPLE);
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    // mode three behaves as real
    assign cplx_out = (r_mode == MODE_HILBERT) || (r_mode == MODE_COMPLEX);
    assign cplx_in  = (r_mode == MODE_COMPLEX);
    assign idx_ok   = int'(in_idx) < MAX_TAPS;

    assign taps_m1 = r_taps - TC_W'(1);
    assign j_last  = (TC_W'(r_j) == taps_m1);
    assign k_last  = (TC_W'(r_k) == taps_m1);

    // guard: position outside the active taps restarts at zero
    assign pos_eff  = (TC_W'(r_pos) < r_taps) ? r_pos : '0;
    assign pos_next = (pos_eff == '0) ? AW'(taps_m1) : pos_eff - AW'(1);
    // first coefficient used against delay slot zero
    assign k_start  = (pos_eff == '0) ? '0 : AW'(r_taps - TC_W'(pos_eff));

    // tap count saturates to 1..MAX_TAPS
    always_comb begin
        if (i_cfg_data == '0) begin
            taps_sat = TC_W'(1);
        end else if (CMP_W'(i_cfg_data) > CMP_W'(MAX_TAPS)) begin
            taps_sat = TC_W'(MAX_TAPS);
        end else begin
            taps_sat = TC_W'(i_cfg_data);
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_j      = r_j;
        n_k      = r_k;
        n_pos    = r_pos;
        n_taps   = r_taps;
        n_mode   = r_mode;
        dl_we    = 1'b0;
        dl_waddr = r_j;
        dl_wre   = '0;
        dl_wim   = '0;
        ci_we    = 1'b0;
        cq_we    = 1'b0;
        cap      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_op)
                        OP_SAMPLE: begin
                            // new sample goes in before the sweep reads it
                            dl_we    = 1'b1;
                            dl_waddr = pos_eff;
                            dl_wre   = in_re;
                            dl_wim   = cplx_in ? in_im : in_re;
                            n_j      = '0;
                            n_k      = k_start;
                            n_pos    = pos_next;
                            n_state  = ST_RUN;
                        end
                        OP_COEF_I: begin
                            ci_we = idx_ok;
                        end
                        OP_COEF_Q: begin
                            cq_we = idx_ok;
                        end
                        OP_CLEAR: begin
                            n_j     = '0;
                            n_pos   = '0;
                            n_state = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                dl_we = 1'b1;
                if (j_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            ST_RUN: begin
                n_k = k_last ? '0 : r_k + AW'(1);
                if (j_last) begin
                    n_state = ST_WAIT;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            ST_WAIT: begin
                if (mac_done && out_free) begin
                    cap     = 1'b1;
                    n_state = ST_IDLE;
                end
            end
        endcase

        // register writes must arrive only while idle, not enforced; tap count restarts the line
        if (cfg_acc) begin
            if (i_cfg_index == REG_TAP_COUNT) begin
                n_taps  = taps_sat;
                n_j     = '0;
                n_pos   = '0;
                n_state = ST_CLEAR;
            end else begin
                n_mode = i_cfg_data[MODE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_j     <= '0;
            r_k     <= '0;
            r_pos   <= '0;
            r_taps  <= TC_W'(1);
            r_mode  <= MODE_REAL;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_k     <= n_k;
            r_pos   <= n_pos;
            r_taps  <= n_taps;
            r_mode  <= n_mode;
        end
    end

    // delay-line memories: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (dl_we) begin
            r_dl_re[dl_waddr] <= dl_wre;
            r_dl_im[dl_waddr] <= dl_wim;
        end
        r_rd_dre <= r_dl_re[r_j];
        r_rd_dim <= r_dl_im[r_j];
    end

    // coefficient memories
    always_ff @(posedge i_clk) begin
        if (ci_we) begin
            r_cf_i[AW'(in_idx)] <= in_coef;
        end
        if (cq_we) begin
            r_cf_q[AW'(in_idx)] <= in_coef;
        end
        r_rd_ci <= r_cf_i[r_k];
        r_rd_cq <= r_cf_q[r_k];
    end

    // control aligned with read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_RUN);
        end
        r_rd_first <= (r_j == '0);
        r_rd_last  <= j_last;
        r_rd_cplx  <= cplx_out;
    end

    assign mac_ctrl = '{start: smp_acc, vld: r_rd_vld, first: r_rd_first,
                        last: r_rd_last, cplx: r_rd_cplx};

    firc_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .MAX_TAPS    (MAX_TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_dre   (r_rd_dre),
        .i_dim   (r_rd_dim),
        .i_cre   (r_rd_ci),
        .i_cim   (r_rd_cq),
        .o_done  (mac_done),
        .o_re    (mac_re),
        .o_im    (mac_im),
        .o_ovf   (mac_ovf)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cap) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cap) begin
            r_out_re  <= mac_re;
            r_out_im  <= mac_im;
            r_out_ovf <= mac_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_im, r_out_re});
    assign m_axis_tuser  = r_out_ovf;

    // checks; the coefficient address only matters during a sum
    `FIRC_ASSERT_NOW(a_addr_in_range, i_clk, i_rst_n,
        (r_state == ST_RUN) || (r_state == ST_CLEAR),
        (TC_W'(r_j) < r_taps) && ((r_state != ST_RUN) || (TC_W'(r_k) < r_taps)),
        "tap address beyond tap_count")
    `FIRC_ASSERT_NOW(a_pos_in_range, i_clk, i_rst_n, 1'b1,
        TC_W'(r_pos) < r_taps,
        "write position beyond tap_count")
    `FIRC_ASSERT_NOW(a_done_in_wait, i_clk, i_rst_n, $rose(mac_done),
        $past(r_state) == ST_WAIT,
        "sum finished outside the wait state")
    `FIRC_ASSERT_NEXT(a_cap_sets_valid, i_clk, i_rst_n, cap,
        r_out_valid && (r_state == ST_IDLE),
        "captured result not presented")

endmodule
